>>> rtl/jdm_pkg.sv
// jdm_pkg: shared constants for the joystick differential mixer
// register indexes, reset values and datapath widths
// no dependencies
package jdm_pkg;

  localparam int RANGE_MAX = 255;

  localparam int AXIS_W = 9;
  localparam int CFG_W  = 8;
  localparam int TDATA_W = 24;

  // register indexes on the configuration port
  localparam logic REG_RANGE = 1'b0;
  localparam logic REG_PIVOT = 1'b1;

  localparam logic [CFG_W-1:0] RANGE_RESET = 8'd127;
  localparam logic [CFG_W-1:0] PIVOT_RESET = 8'd32;

  // divider geometry
  localparam int Q_W   = 8;   // quotient magnitude bits
  localparam int D_W   = 16;  // divisor l*r
  localparam int REM_W = 27;  // numerator magnitude / remainder

endpackage

>>> rtl/joystick_differential_mixer.sv
// joystick_differential_mixer: one-stick tank steering mixer
// accepts one item per cycle unless out_tready back pressure stalls the pipeline
// divider is restoring, one quotient bit per stage, eight stages deep
// full pipeline with per-stage valids; bubbles collapse under back pressure
// rst_n (sync, active low) clears valids and loads range 127, pivot 32
// depends on jdm_pkg
module joystick_differential_mixer
  import jdm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // [8:0] stick_x, [17:9] stick_y, rest zero
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata   // [8:0] left_drive, [17:9] right_drive, rest zero
);

  localparam int NST = 13;
  localparam int DIV0 = 3;  // stage index of the divider entry register

  logic [CFG_W-1:0] range_r, pivot_r;
  logic [NST-1:0]   v_r;
  logic [NST:0]     en;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_RESET;
      pivot_r <= PIVOT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE: range_r <= cfg_wdata;
        REG_PIVOT: pivot_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  always_comb begin
    en[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------- stage 1: clamp, premix, pivot weight ----------------
  logic signed [8:0] sx, sy, cx, cy, nx, ny;
  logic signed [9:0] x10, y10, rs10, nrs10;
  logic [7:0] r_c, ax_mag, ay_mag, dim, a_c, l_eff, w_c, pl_c, pr_c;
  logic       dirsel;

  assign sx = $signed(in_tdata[8:0]);
  assign sy = $signed(in_tdata[17:9]);

  always_comb begin
    r_c = (32'(range_r) > RANGE_MAX) ? CFG_W'(RANGE_MAX) : range_r;
    rs10  = $signed({2'b00, r_c});
    nrs10 = -rs10;
    x10 = {sx[8], sx};
    y10 = {sy[8], sy};
    if (x10 > rs10)       cx = $signed(rs10[8:0]);
    else if (x10 < nrs10) cx = $signed(nrs10[8:0]);
    else                  cx = sx;
    if (y10 > rs10)       cy = $signed(rs10[8:0]);
    else if (y10 < nrs10) cy = $signed(nrs10[8:0]);
    else                  cy = sy;
    nx = -cx;
    ny = -cy;
    ax_mag = cx[8] ? nx[7:0] : cx[7:0];
    ay_mag = cy[8] ? ny[7:0] : cy[7:0];
    dim    = r_c - ax_mag;
    a_c    = (ay_mag <= pivot_r) ? (pivot_r - ay_mag) : 8'd0;
    // no pivot when the limit is zero: weight stays 0, scale by r alone
    l_eff  = (pivot_r == 8'd0) ? 8'd1 : pivot_r;
    w_c    = l_eff - a_c;
    // full drive on the outer wheel, dimmed drive on the inner one
    dirsel = ~cx[8] ^ cy[8];
    pl_c   = dirsel ? r_c : dim;
    pr_c   = dirsel ? dim : r_c;
  end

  logic signed [8:0] x1_r, y1_r;
  logic [7:0] r1_r, l1_r, a1_r, w1_r, pl1_r, pr1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r  <= cx;
      y1_r  <= cy;
      r1_r  <= r_c;
      l1_r  <= l_eff;
      a1_r  <= a_c;
      w1_r  <= w_c;
      pl1_r <= pl_c;
      pr1_r <= pr_c;
    end
  end

  // ---------------- stage 2: first products ----------------
  logic [15:0]        wl_nxt, wr_nxt, d_nxt;
  logic signed [17:0] ax_nxt;

  always_comb begin
    wl_nxt = 16'(w1_r) * 16'(pl1_r);
    wr_nxt = 16'(w1_r) * 16'(pr1_r);
    ax_nxt = 18'($signed({1'b0, a1_r})) * 18'(x1_r);
    // zero range gives a zero numerator; keep the divisor nonzero
    d_nxt  = (r1_r == 8'd0) ? 16'd1 : 16'(l1_r) * 16'(r1_r);
  end

  logic [15:0]        wl2_r, wr2_r, d2_r;
  logic signed [17:0] ax2_r;
  logic signed [8:0]  y2_r;
  logic [7:0]         r2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      wl2_r <= wl_nxt;
      wr2_r <= wr_nxt;
      d2_r  <= d_nxt;
      ax2_r <= ax_nxt;
      y2_r  <= y1_r;
      r2_r  <= r1_r;
    end
  end

  // ---------------- stage 3: second products ----------------
  logic signed [25:0] t1l_nxt, t1r_nxt;
  logic signed [26:0] t2_nxt;

  always_comb begin
    t1l_nxt = 26'($signed({1'b0, wl2_r})) * 26'(y2_r);
    t1r_nxt = 26'($signed({1'b0, wr2_r})) * 26'(y2_r);
    t2_nxt  = 27'(ax2_r) * 27'($signed({1'b0, r2_r}));
  end

  logic signed [25:0] t1l3_r, t1r3_r;
  logic signed [26:0] t23_r;
  logic [D_W-1:0]     d3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t1l3_r <= t1l_nxt;
      t1r3_r <= t1r_nxt;
      t23_r  <= t2_nxt;
      d3_r   <= d2_r;
    end
  end

  // ---------------- stage 4: numerator sum and magnitude ----------------
  logic signed [26:0] nl, nr, nl_neg, nr_neg;

  always_comb begin
    nl = {t1l3_r[25], t1l3_r} + t23_r;   // pivot +x on the left
    nr = {t1r3_r[25], t1r3_r} - t23_r;   // pivot -x on the right
    nl_neg = -nl;
    nr_neg = -nr;
  end

  logic [REM_W-1:0] reml_r [0:Q_W];
  logic [REM_W-1:0] remr_r [0:Q_W];
  logic [Q_W-1:0]   ql_r   [0:Q_W];
  logic [Q_W-1:0]   qr_r   [0:Q_W];
  logic             negl_r [0:Q_W];
  logic             negr_r [0:Q_W];
  logic [D_W-1:0]   dd_r   [0:Q_W];

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      reml_r[0] <= nl[26] ? nl_neg : nl;
      remr_r[0] <= nr[26] ? nr_neg : nr;
      ql_r[0]   <= '0;
      qr_r[0]   <= '0;
      negl_r[0] <= nl[26];
      negr_r[0] <= nr[26];
      dd_r[0]   <= d3_r;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    localparam int SH = Q_W - j;
    logic [REM_W-1:0] ds;
    logic [REM_W-1:0] reml_nxt, remr_nxt;
    logic [Q_W-1:0]   ql_nxt, qr_nxt;

    always_comb begin
      ds       = REM_W'(dd_r[j-1]) << SH;
      reml_nxt = reml_r[j-1];
      remr_nxt = remr_r[j-1];
      ql_nxt   = ql_r[j-1];
      qr_nxt   = qr_r[j-1];
      if (reml_r[j-1] >= ds) begin
        reml_nxt = reml_r[j-1] - ds;
        ql_nxt   = ql_r[j-1] | (Q_W'(1) << SH);
      end
      if (remr_r[j-1] >= ds) begin
        remr_nxt = remr_r[j-1] - ds;
        qr_nxt   = qr_r[j-1] | (Q_W'(1) << SH);
      end
    end

    always_ff @(posedge clk) begin
      if (en[DIV0 + j]) begin
        reml_r[j] <= reml_nxt;
        remr_r[j] <= remr_nxt;
        ql_r[j]   <= ql_nxt;
        qr_r[j]   <= qr_nxt;
        negl_r[j] <= negl_r[j-1];
        negr_r[j] <= negr_r[j-1];
        dd_r[j]   <= dd_r[j-1];
      end
    end
  end

  // ---------------- output: restore sign ----------------
  logic signed [8:0] ql_s, qr_s, left_nxt, right_nxt;
  logic signed [8:0] left_r, right_r;

  always_comb begin
    ql_s      = $signed({1'b0, ql_r[Q_W]});
    qr_s      = $signed({1'b0, qr_r[Q_W]});
    left_nxt  = negl_r[Q_W] ? -ql_s : ql_s;
    right_nxt = negr_r[Q_W] ? -qr_s : qr_s;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {6'd0, right_r, left_r};

endmodule
